[design/lru_pkg.sv]
// Shared types and constants of the line rasterizer.
`timescale 1ns / 1ps
package lru_pkg;

	localparam int COORD_BITS  = 6;
	localparam int ADDR_BITS   = 2 * COORD_BITS;
	localparam int PITCH_BITS  = COORD_BITS + 1;
	localparam int ERR_BITS    = COORD_BITS + 1;
	localparam int PITCH_RESET = 1 << COORD_BITS;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [ADDR_BITS-1:0]  addr_t;
	typedef logic [PITCH_BITS-1:0] pitch_t;
	typedef logic [ERR_BITS-1:0]   err_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} seg_in_t;

	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		addr_t  pixel_address;
		logic   last_pixel;
	} pixel_out_t;

	// One classified segment, in major-axis order
	typedef struct packed {
		coord_t maj_start;
		coord_t mnr_start;
		coord_t major_delta;
		coord_t minor_delta;
		logic   minor_step_negative;
		logic   x_is_major;
	} job_t;

	typedef enum logic {
		WALK_IDLE,
		WALK_RUN
	} walk_state_t;

endpackage

[design/lru_front.sv]
// Front end: accepts segments, orders them along the major axis, drops empty ones.
`timescale 1ns / 1ps
module lru_front (
	input  logic            seg_valid,
	output logic            seg_stall,
	input  lru_pkg::seg_in_t seg,
	input  logic            q_full,
	output logic            q_push,
	output lru_pkg::job_t   q_job
);
	import lru_pkg::*;

	coord_t adx, ady;
	logic   x_major, swap;
	coord_t mnr_end;

	always_comb begin
		adx     = (seg.end_x >= seg.start_x) ? seg.end_x - seg.start_x : seg.start_x - seg.end_x;
		ady     = (seg.end_y >= seg.start_y) ? seg.end_y - seg.start_y : seg.start_y - seg.end_y;
		x_major = (adx >= ady);
		swap    = x_major ? (seg.end_x < seg.start_x) : (seg.end_y < seg.start_y);

		if (x_major) begin
			q_job.maj_start = swap ? seg.end_x : seg.start_x;
			q_job.mnr_start = swap ? seg.end_y : seg.start_y;
			mnr_end         = swap ? seg.start_y : seg.end_y;
			q_job.major_delta = adx;
			q_job.minor_delta = ady;
		end else begin
			q_job.maj_start = swap ? seg.end_y : seg.start_y;
			q_job.mnr_start = swap ? seg.end_x : seg.start_x;
			mnr_end         = swap ? seg.start_x : seg.end_x;
			q_job.major_delta = ady;
			q_job.minor_delta = adx;
		end
		q_job.minor_step_negative = (mnr_end < q_job.mnr_start);
		q_job.x_is_major          = x_major;
	end

	assign seg_stall = q_full;
	// a segment with equal endpoints is taken and dropped
	assign q_push = seg_valid && !q_full && ((adx != '0) || (ady != '0));

endmodule

[design/lru_queue.sv]
// Small register queue of classified segments between front end and walker.
`timescale 1ns / 1ps
module lru_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lru_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output lru_pkg::job_t pop_job,
	output logic          empty
);
	import lru_pkg::*;

	localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	job_t                entries_q [DEPTH];
	logic [IDX_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push, do_pop;

	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == IDX_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == IDX_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			entries_q[wr_ptr_q] <= push_job;
	end

endmodule

[design/lru_walker.sv]
// Back end: steps one segment a pixel per cycle into the output register while the output is not stalled.
`timescale 1ns / 1ps
module lru_walker (
	input  logic               clk,
	input  logic               arst_n,
	input  lru_pkg::pitch_t    row_pitch,
	input  logic               q_empty,
	input  lru_pkg::job_t      q_job,
	output logic               q_pop,
	output logic               pix_valid,
	input  logic               pix_stall,
	output lru_pkg::pixel_out_t pix
);
	import lru_pkg::*;

	localparam int PROD_BITS = COORD_BITS + PITCH_BITS;

	walk_state_t state_q, state_d;

	coord_t maj_q, mnr_q, major_q, minor_q, steps_q;
	err_t   err_q;
	logic   neg_q, xmaj_q;

	logic       out_valid_q;
	pixel_out_t out_q;

	logic                 can_emit, load, step, last;
	err_t                 err_sum, err_next;
	coord_t               mnr_next, px, py;
	logic [PROD_BITS-1:0] prod, addr_sum;

	assign can_emit = !out_valid_q || !pix_stall;

	always_comb begin
		err_sum  = err_q + {1'b0, minor_q};
		err_next = err_sum;
		mnr_next = mnr_q;
		if (err_sum >= {1'b0, major_q}) begin
			err_next = err_sum - {1'b0, major_q};
			mnr_next = neg_q ? mnr_q - 1'b1 : mnr_q + 1'b1;
		end
		px       = xmaj_q ? maj_q : mnr_next;
		py       = xmaj_q ? mnr_next : maj_q;
		prod     = PROD_BITS'(py) * PROD_BITS'(row_pitch);
		addr_sum = prod + PROD_BITS'(px);
		last     = (steps_q == COORD_BITS'(1));
	end

	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		step    = 1'b0;
		case (state_q)
			WALK_IDLE: begin
				if (!q_empty) begin
					load    = 1'b1;
					state_d = WALK_RUN;
				end
			end
			WALK_RUN: begin
				if (can_emit) begin
					step = 1'b1;
					if (last)
						state_d = WALK_IDLE;
				end
			end
			default: state_d = WALK_IDLE;
		endcase
	end

	assign q_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= WALK_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step)
			out_valid_q <= 1'b1;
		else if (!pix_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			maj_q   <= q_job.maj_start;
			mnr_q   <= q_job.mnr_start;
			major_q <= q_job.major_delta;
			minor_q <= q_job.minor_delta;
			steps_q <= q_job.major_delta;
			neg_q   <= q_job.minor_step_negative;
			xmaj_q  <= q_job.x_is_major;
			err_q   <= '0;
		end else if (step) begin
			maj_q   <= maj_q + 1'b1;
			mnr_q   <= mnr_next;
			err_q   <= err_next;
			steps_q <= steps_q - 1'b1;
		end
		if (step) begin
			out_q.pixel_x       <= px;
			out_q.pixel_y       <= py;
			out_q.pixel_address <= addr_sum[ADDR_BITS-1:0];
			out_q.last_pixel    <= last;
		end
	end

	assign pix_valid = out_valid_q;
	assign pix       = out_q;

endmodule

[design/line_rasterizer_unit.sv]
// Top level of the line rasterizer: pitch register, front end, queue and walker.
`timescale 1ns / 1ps
// Segment channel (seg_valid, seg_stall, seg): one beat is one segment, two
// endpoints. The front end orders it along its major axis in the same cycle
// and writes it to a short queue; segments with equal endpoints are taken
// and produce nothing. seg_stall is high only while the queue is full.
// Pixel channel (pix_valid, pix_stall, pix): one beat per plotted pixel,
// x, y, address x + y * pitch and a flag on the last pixel of a segment.
// The walker pulls a segment from the queue when idle, then emits one
// pixel per cycle from its output register while pix_stall is low; a
// segment passes the queue, the walker's load and its output register
// before its first pixel appears. The walker's single step per cycle
// sets the rate. While pix_stall is high and a pixel beat is waiting, the
// walker holds its position and the output beat stays unchanged; the front
// end keeps filling the queue.
// Configuration (cfg_valid, cfg_ready, cfg_pitch): always ready, writes the
// row pitch; write it only while no segment is in flight.
// Reset clears the queue and the walker and sets the pitch to 64.
module line_rasterizer_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                seg_valid,
	output logic                seg_stall,
	input  lru_pkg::seg_in_t    seg,
	output logic                pix_valid,
	input  logic                pix_stall,
	output lru_pkg::pixel_out_t pix,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  lru_pkg::pitch_t     cfg_pitch
);
	import lru_pkg::*;

	pitch_t pitch_q;
	job_t   push_job, pop_job;
	logic   q_full, q_empty, q_push, q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pitch_q <= PITCH_BITS'(PITCH_RESET);
		else if (cfg_valid && cfg_ready)
			pitch_q <= cfg_pitch;
	end

	lru_front u_front (
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.seg       (seg),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	lru_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	lru_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_pitch (pitch_q),
		.q_empty   (q_empty),
		.q_job     (pop_job),
		.q_pop     (q_pop),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix)
	);

endmodule
